// ----- sv/byte_range_to_block_span_top_assert.svh -----
// ---------------------------------------------------------------------------
// byte range to block span assertion macros
// shared property forms for the span block checks
// ---------------------------------------------------------------------------
`ifndef BYTE_RANGE_TO_BLOCK_SPAN_TOP_ASSERT_SVH
`define BYTE_RANGE_TO_BLOCK_SPAN_TOP_ASSERT_SVH

// same-cycle implication
`define BRBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/brbs_pkg.sv -----
// ---------------------------------------------------------------------------
// byte range to block span package
// register indexes, reset values and the sideband carried down the divider
// ---------------------------------------------------------------------------
package brbs_pkg;

  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PART_FIRST = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PART_LAST  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BLOCK_SIZE = 2'd2;

  localparam logic [15:0] BLOCK_SIZE_RESET = 16'd512;

  // control that rides along with each beat through the divider cells
  typedef struct packed {
    logic valid;
    logic neg;       // offset counted back from partition end
    logic over_neg;  // negative branch: count runs past partition end
    logic partial;
    logic pre_err;   // geometry or count error known at entry
  } side_t;

endpackage

// ----- sv/brbs_req_if.sv -----
// ---------------------------------------------------------------------------
// request channel
// byte offset, byte count and partial flag with valid/ready
// ---------------------------------------------------------------------------
interface brbs_req_if #(
  parameter int OFFSET_WIDTH = 48
) ();
  logic                           valid;
  logic                           ready;
  logic signed [OFFSET_WIDTH-1:0] byte_offset;
  logic        [31:0]             byte_count;
  logic                           partial_ok;

  modport source (output valid, output byte_offset, output byte_count,
                  output partial_ok, input ready);
  modport sink   (input valid, input byte_offset, input byte_count,
                  input partial_ok, output ready);
endinterface

// ----- sv/brbs_rsp_if.sv -----
// ---------------------------------------------------------------------------
// response channel
// block span result with valid/ready
// ---------------------------------------------------------------------------
interface brbs_rsp_if #(
  parameter int BLOCK_NUM_WIDTH = 32
) ();
  logic                       valid;
  logic                       ready;
  logic                       range_error;
  logic [BLOCK_NUM_WIDTH-1:0] first_block;
  logic [15:0]                first_byte_pos;
  logic [BLOCK_NUM_WIDTH-1:0] last_block;
  logic [15:0]                last_byte_pos;
  logic [BLOCK_NUM_WIDTH-1:0] whole_blocks;

  modport source (output valid, output range_error, output first_block,
                  output first_byte_pos, output last_block, output last_byte_pos,
                  output whole_blocks, input ready);
  modport sink   (input valid, input range_error, input first_block,
                  input first_byte_pos, input last_block, input last_byte_pos,
                  input whole_blocks, output ready);
endinterface

// ----- sv/byte_range_to_block_span_top.sv -----
// ---------------------------------------------------------------------------
// byte range to block span
// maps a signed byte offset and count onto the blocks of a partition
// ---------------------------------------------------------------------------
// Accepts one request every cycle while the skid entry is empty. A request goes
// through an entry register, a chain of divider cells (one per quotient bit,
// max(OFFSET_WIDTH, 33) of them, each dividing the first-byte and last-byte
// distances by the block size in parallel), a span register and the output
// register. A skid entry behind the output register lets the chain keep moving
// while one result waits; the request side stalls only when both are full.
// Configuration must be written while no request is in flight.
`include "byte_range_to_block_span_top_assert.svh"

module byte_range_to_block_span_top import brbs_pkg::*; #(
  parameter int BLOCK_NUM_WIDTH = 32,
  parameter int OFFSET_WIDTH    = 48
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]             cfg_index,
  input  logic [((BLOCK_NUM_WIDTH > 16) ? BLOCK_NUM_WIDTH : 16)-1:0] cfg_data,
  brbs_req_if.sink                               req,
  brbs_rsp_if.source                             rsp
);

  localparam int BW   = BLOCK_NUM_WIDTH;
  localparam int OW   = OFFSET_WIDTH;
  localparam int DW   = (OW > 33) ? OW : 33;
  localparam int CW   = (DW > BW) ? DW : BW;

  // configuration
  logic [BW-1:0] pf, pl;
  logic [15:0]   bs;

  always_ff @(posedge clk) begin
    if (rst) begin
      pf <= '0;
      pl <= '0;
      bs <= BLOCK_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PART_FIRST: pf <= BW'(cfg_data);
        REG_PART_LAST:  pl <= BW'(cfg_data);
        REG_BLOCK_SIZE: bs <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic svalid;
  assign en = !svalid;
  assign req.ready = en;

  // entry stage
  logic [OW-1:0] raw, mag, back_dist;
  logic [DW-1:0] cnt_x, mag_x, a_in, b_in;
  logic          neg_in, over_in, pre_err_in;

  always_comb begin
    raw    = req.byte_offset;
    neg_in = raw[OW-1];
    mag    = OW'(~raw + 1'b1);
    back_dist = OW'(mag - 1'b1);
    cnt_x  = DW'(req.byte_count);
    mag_x  = DW'(mag);
    over_in = cnt_x > mag_x;
    pre_err_in = (bs == 16'd0) || (pf > pl) || (req.byte_count == 32'd0);
    if (neg_in) begin
      a_in = DW'(back_dist);
      b_in = over_in ? '0 : DW'(mag_x - cnt_x);
    end else begin
      a_in = DW'(raw);
      b_in = DW'(DW'(raw) + cnt_x - 1'b1);
    end
  end

  side_t         side  [0:DW];
  logic [DW-1:0] a_dvd [0:DW];
  logic [DW-1:0] b_dvd [0:DW];
  logic [DW-1:0] a_q   [0:DW];
  logic [DW-1:0] b_q   [0:DW];
  logic [15:0]   a_rem [0:DW];
  logic [15:0]   b_rem [0:DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      side[0].valid <= 1'b0;
    end else if (en) begin
      side[0].valid <= req.valid;
    end
    if (en) begin
      side[0].neg      <= neg_in;
      side[0].over_neg <= neg_in && over_in;
      side[0].partial  <= req.partial_ok;
      side[0].pre_err  <= pre_err_in;
      a_dvd[0] <= a_in;
      b_dvd[0] <= b_in;
    end
  end

  assign a_q[0]   = '0;
  assign b_q[0]   = '0;
  assign a_rem[0] = '0;
  assign b_rem[0] = '0;

  for (genvar k = 0; k < DW; k++) begin : g_cell
    brbs_div_cell #(.DW(DW), .BIT(DW - 1 - k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .bs        (bs),
      .side_in   (side[k]),
      .a_dvd_in  (a_dvd[k]),
      .b_dvd_in  (b_dvd[k]),
      .a_q_in    (a_q[k]),
      .b_q_in    (b_q[k]),
      .a_rem_in  (a_rem[k]),
      .b_rem_in  (b_rem[k]),
      .side_out  (side[k+1]),
      .a_dvd_out (a_dvd[k+1]),
      .b_dvd_out (b_dvd[k+1]),
      .a_q_out   (a_q[k+1]),
      .b_q_out   (b_q[k+1]),
      .a_rem_out (a_rem[k+1]),
      .b_rem_out (b_rem[k+1])
    );
  end

  // span stage: block numbers and byte positions
  side_t         tail;
  logic [BW-1:0] span, bstart_c, bend_c;
  logic [15:0]   bsm1, pstart_c, pend_c;
  logic [CW-1:0] span_x;
  logic          start_err, end_over, err_c;

  always_comb begin
    tail   = side[DW];
    span   = pl - pf;
    span_x = CW'(span);
    bsm1   = bs - 16'd1;
    start_err = CW'(a_q[DW]) > span_x;
    if (tail.neg) begin
      bstart_c = pl - BW'(a_q[DW]);
      pstart_c = bsm1 - a_rem[DW];
      end_over = tail.over_neg;
    end else begin
      bstart_c = pf + BW'(a_q[DW]);
      pstart_c = a_rem[DW];
      end_over = CW'(b_q[DW]) > span_x;
    end
    if (end_over) begin
      bend_c = pl;
      pend_c = bsm1;
    end else if (tail.neg) begin
      bend_c = pl - BW'(b_q[DW]);
      pend_c = bsm1 - b_rem[DW];
    end else begin
      bend_c = pf + BW'(b_q[DW]);
      pend_c = b_rem[DW];
    end
    err_c = tail.pre_err || start_err || (end_over && !tail.partial);
  end

  logic          s1_valid, s1_err;
  logic [BW-1:0] s1_bstart, s1_bend;
  logic [15:0]   s1_pstart, s1_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_err    <= err_c;
      s1_bstart <= bstart_c;
      s1_bend   <= bend_c;
      s1_pstart <= pstart_c;
      s1_pend   <= pend_c;
    end
  end

  // whole block count
  logic [BW-1:0] diff, diff_m1, limit, multi;
  logic [1:0]    flags;
  logic          r_err;
  logic [BW-1:0] r_first, r_last, r_whole;
  logic [15:0]   r_fpos, r_lpos;

  always_comb begin
    diff    = s1_bend - s1_bstart;
    diff_m1 = diff - 1'b1;
    flags   = 2'({1'b0, s1_pstart == 16'd0} + {1'b0, s1_pend == bsm1});
    limit   = {BW{1'b1}} - BW'(flags);
    if (diff == '0) begin
      multi = (flags != 2'd0) ? BW'(flags - 2'd1) : '0;
    end else if (diff_m1 > limit) begin
      multi = {BW{1'b1}};
    end else begin
      multi = diff_m1 + BW'(flags);
    end
    r_err   = s1_err;
    r_first = s1_err ? '0 : s1_bstart;
    r_fpos  = s1_err ? '0 : s1_pstart;
    r_last  = s1_err ? '0 : s1_bend;
    r_lpos  = s1_err ? '0 : s1_pend;
    r_whole = s1_err ? '0 : multi;
  end

  // output register and skid entry
  logic          ovalid, take;
  logic          o_err, s_err;
  logic [BW-1:0] o_first, o_last, o_whole, s_first, s_last, s_whole;
  logic [15:0]   o_fpos, o_lpos, s_fpos, s_lpos;

  assign take = ovalid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      svalid <= 1'b0;
    end else if (!ovalid || take) begin
      if (svalid) begin
        ovalid <= 1'b1;
        svalid <= 1'b0;
      end else begin
        ovalid <= s1_valid;
      end
    end else if (s1_valid && en) begin
      svalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ovalid || take) begin
      if (svalid) begin
        o_err <= s_err; o_first <= s_first; o_fpos <= s_fpos;
        o_last <= s_last; o_lpos <= s_lpos; o_whole <= s_whole;
      end else begin
        o_err <= r_err; o_first <= r_first; o_fpos <= r_fpos;
        o_last <= r_last; o_lpos <= r_lpos; o_whole <= r_whole;
      end
    end else if (en) begin
      s_err <= r_err; s_first <= r_first; s_fpos <= r_fpos;
      s_last <= r_last; s_lpos <= r_lpos; s_whole <= r_whole;
    end
  end

  assign rsp.valid          = ovalid;
  assign rsp.range_error    = o_err;
  assign rsp.first_block    = o_first;
  assign rsp.first_byte_pos = o_fpos;
  assign rsp.last_block     = o_last;
  assign rsp.last_byte_pos  = o_lpos;
  assign rsp.whole_blocks   = o_whole;

  `BRBS_ASSERT_NOW(a_skid_behind_out, svalid, ovalid, "skid full with empty output")
  `BRBS_ASSERT_NEXT(a_skid_drains, take && svalid, ovalid && !svalid, "skid beat not moved")
  `BRBS_ASSERT_NOW(a_err_zeroed, ovalid && o_err, o_first == '0 && o_whole == '0 && o_last == '0, "error beat not zeroed")

endmodule

// ----- sv/brbs_div_cell.sv -----
// ---------------------------------------------------------------------------
// divider cell
// one restoring step for both dividends: one quotient bit per cell
// ---------------------------------------------------------------------------
module brbs_div_cell import brbs_pkg::*; #(
  parameter int DW  = 48,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [15:0]   bs,
  input  side_t         side_in,
  input  logic [DW-1:0] a_dvd_in,
  input  logic [DW-1:0] b_dvd_in,
  input  logic [DW-1:0] a_q_in,
  input  logic [DW-1:0] b_q_in,
  input  logic [15:0]   a_rem_in,
  input  logic [15:0]   b_rem_in,
  output side_t         side_out,
  output logic [DW-1:0] a_dvd_out,
  output logic [DW-1:0] b_dvd_out,
  output logic [DW-1:0] a_q_out,
  output logic [DW-1:0] b_q_out,
  output logic [15:0]   a_rem_out,
  output logic [15:0]   b_rem_out
);

  logic [16:0]   a_try, b_try;
  logic          a_ge, b_ge;
  logic [15:0]   a_rem_next, b_rem_next;
  logic [DW-1:0] a_q_next, b_q_next;

  always_comb begin
    a_try = {a_rem_in, a_dvd_in[BIT]};
    b_try = {b_rem_in, b_dvd_in[BIT]};
    a_ge  = a_try >= {1'b0, bs};
    b_ge  = b_try >= {1'b0, bs};
    // below the divisor the trial value fits in 16 bits
    a_rem_next = a_ge ? 16'(a_try - {1'b0, bs}) : a_try[15:0];
    b_rem_next = b_ge ? 16'(b_try - {1'b0, bs}) : b_try[15:0];
    a_q_next = a_q_in;
    b_q_next = b_q_in;
    a_q_next[BIT] = a_ge;
    b_q_next[BIT] = b_ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out.valid <= side_in.valid;
    end
    if (en) begin
      side_out.neg      <= side_in.neg;
      side_out.over_neg <= side_in.over_neg;
      side_out.partial  <= side_in.partial;
      side_out.pre_err  <= side_in.pre_err;
      a_dvd_out <= a_dvd_in;
      b_dvd_out <= b_dvd_in;
      a_q_out   <= a_q_next;
      b_q_out   <= b_q_next;
      a_rem_out <= a_rem_next;
      b_rem_out <= b_rem_next;
    end
  end

endmodule

// ----- tb/sv/byte_range_to_block_span_top_tb.sv -----
// ---------------------------------------------------------------------------
// byte range to block span testbench
// drives offset/count requests through several partition settings, predicts
// each block span in the bench and compares every response beat field by field
// ---------------------------------------------------------------------------
module byte_range_to_block_span_top_tb;
  import brbs_pkg::*;

  localparam int OFFSET_WIDTH    = 48;
  localparam int BLOCK_NUM_WIDTH = 32;
  localparam int SETTLE_CYCLES   = 64;   // request to result pipeline is 51 deep
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 58;
  localparam longint unsigned BLK_MASK = 64'hFFFF_FFFF;

  typedef struct packed {
    logic        err;
    logic [31:0] first_blk;
    logic [15:0] first_pos;
    logic [31:0] last_blk;
    logic [15:0] last_pos;
    logic [31:0] whole;
  } span_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                   kind;
    logic [CFG_INDEX_WIDTH-1:0]  index;
    logic [31:0]                 data;
    logic [OFFSET_WIDTH-1:0]     offset;
    logic [31:0]                 count;
    logic                        partial;
    bit                          typed;
    span_t                       span;
  } stim_row_t;

  localparam span_t SPAN_ERR = '{err: 1'b1, default: '0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_PART_FIRST;
  logic [31:0] cfg_data = '0;

  brbs_req_if #(.OFFSET_WIDTH(OFFSET_WIDTH)) req_ch ();
  brbs_rsp_if #(.BLOCK_NUM_WIDTH(BLOCK_NUM_WIDTH)) rsp_ch ();

  byte_range_to_block_span_top #(
    .BLOCK_NUM_WIDTH(BLOCK_NUM_WIDTH),
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  // shadow of the partition registers
  longint unsigned part_first = 0;
  longint unsigned part_last  = 0;
  longint unsigned blk_size   = BLOCK_SIZE_RESET;

  span_t pending_spans[$];
  int    fails = 0;
  int    burst_left = 0;
  bit    long_hold = 0;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.byte_offset = '0;
    req_ch.byte_count = '0;
    req_ch.partial_ok = 1'b0;
    rsp_ch.ready = 1'b0;
  end

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic span_t predict_span(logic [OFFSET_WIDTH-1:0] raw, logic [31:0] cnt_in,
                                         logic partial);
    longint unsigned bs, pf, pl, span, cnt, bstart, bend, pstart, pend;
    longint unsigned diff, flags, multi, m, d, de, last;
    logic [OFFSET_WIDTH-1:0] mag;
    span_t r;
    r = SPAN_ERR;
    bs = blk_size;
    pf = part_first;
    pl = part_last;
    cnt = cnt_in;
    if (bs == 0 || pf > pl || cnt == 0) return r;
    span = pl - pf;
    if (raw[OFFSET_WIDTH-1]) begin
      mag = -raw;
      m = mag;
      d = m - 1;
      if (d / bs > span) return r;
      bstart = pl - d / bs;
      pstart = bs - 1 - d % bs;
      if (cnt > m) begin
        if (!partial) return r;
        bend = pl;
        pend = bs - 1;
      end else begin
        de = m - cnt;
        bend = pl - de / bs;
        pend = bs - 1 - de % bs;
      end
    end else begin
      m = raw;
      last = m + cnt - 1;
      if (m / bs > span) return r;
      bstart = pf + m / bs;
      pstart = m % bs;
      if (last / bs > span) begin
        if (!partial) return r;
        bend = pl;
        pend = bs - 1;
      end else begin
        bend = pf + last / bs;
        pend = last % bs;
      end
    end
    diff = bend - bstart;
    flags = longint'(pstart == 0) + longint'(pend == bs - 1);
    if (diff == 0) begin
      multi = (flags > 0) ? flags - 1 : 0;
    end else begin
      multi = diff - 1;
      if (multi > BLK_MASK - flags) multi = BLK_MASK;
      else multi += flags;
    end
    r.err = 1'b0;
    r.first_blk = bstart[31:0];
    r.first_pos = pstart[15:0];
    r.last_blk = bend[31:0];
    r.last_pos = pend[15:0];
    r.whole = multi[31:0];
    return r;
  endfunction

  task automatic drain_and_settle();
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PART_FIRST: part_first = value;
      REG_PART_LAST:  part_last = value;
      REG_BLOCK_SIZE: blk_size = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_partition(logic [31:0] first, logic [31:0] last, logic [15:0] size);
    drain_and_settle();
    write_reg(REG_PART_FIRST, first);
    write_reg(REG_PART_LAST, last);
    write_reg(REG_BLOCK_SIZE, {16'h0, size});
  endtask

  task automatic send_request(logic [OFFSET_WIDTH-1:0] off, logic [31:0] cnt, logic partial,
                              bit typed, span_t typed_span);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
    end
    req_ch.valid <= 1'b1;
    req_ch.byte_offset <= off;
    req_ch.byte_count <= cnt;
    req_ch.partial_ok <= partial;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_spans.push_back(typed ? typed_span : predict_span(off, cnt, partial));
    burst_left--;
  endtask

  task automatic idle_request();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  // offsets mostly land inside the partition, from either end
  task automatic send_random();
    longint unsigned total, pos, rnd;
    logic [OFFSET_WIDTH-1:0] off;
    logic [31:0] cnt;
    rnd = {$urandom, $urandom};
    total = (part_last >= part_first) ? (part_last - part_first + 1) * blk_size : 0;
    if (total > (64'd1 << 47)) total = 64'd1 << 47;
    if (total == 0 || $urandom_range(0, 9) == 0) begin
      off = rnd[OFFSET_WIDTH-1:0];
      pos = 0;
    end else begin
      pos = rnd % total;
      off = $urandom_range(0, 1) ? OFFSET_WIDTH'(pos) : ~OFFSET_WIDTH'(pos);
    end
    case ($urandom_range(0, 9))
      0:       cnt = $urandom;
      1:       cnt = 0;
      2, 3:    cnt = (total > pos && total - pos < 64'hFFFF_FFFF) ?
                     32'(total - pos + $urandom_range(0, 2) - 1) : $urandom;
      default: cnt = $urandom_range(1, 3 * (blk_size + 1));
    endcase
    send_request(off, cnt, $urandom_range(0, 1), 1'b0, SPAN_ERR);
  endtask

  // receiver: checks each result beat and stalls on its own pattern
  initial begin
    int cyc;
    int hold_left;
    cyc = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        span_t want;
        if (pending_spans.size() == 0) begin
          $error("result beat with no request outstanding");
          fails++;
        end else begin
          want = pending_spans.pop_front();
          if (rsp_ch.range_error !== want.err) begin
            $error("range_error exp %0d got %0d", want.err, rsp_ch.range_error);
            fails++;
          end
          if (rsp_ch.first_block !== want.first_blk) begin
            $error("first_block exp %0h got %0h", want.first_blk, rsp_ch.first_block);
            fails++;
          end
          if (rsp_ch.first_byte_pos !== want.first_pos) begin
            $error("first_byte_pos exp %0h got %0h", want.first_pos, rsp_ch.first_byte_pos);
            fails++;
          end
          if (rsp_ch.last_block !== want.last_blk) begin
            $error("last_block exp %0h got %0h", want.last_blk, rsp_ch.last_block);
            fails++;
          end
          if (rsp_ch.last_byte_pos !== want.last_pos) begin
            $error("last_byte_pos exp %0h got %0h", want.last_pos, rsp_ch.last_byte_pos);
            fails++;
          end
          if (rsp_ch.whole_blocks !== want.whole) begin
            $error("whole_blocks exp %0h got %0h", want.whole, rsp_ch.whole_blocks);
            fails++;
          end
        end
      end
      cyc++;
      if (long_hold) begin
        long_hold = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case ((cyc / 64) % 3)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= $urandom_range(0, 1);
          default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  stim_row_t directed_rows[$];

  function automatic stim_row_t item_row(logic [OFFSET_WIDTH-1:0] off, logic [31:0] cnt,
                                         logic partial, bit typed, span_t s);
    stim_row_t r;
    r = '{kind: ROW_ITEM, index: REG_PART_FIRST, data: '0, offset: off, count: cnt,
          partial: partial, typed: typed, span: s};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_INDEX_WIDTH-1:0] idx, logic [31:0] value);
    stim_row_t r;
    r = '{kind: ROW_CFG, index: idx, data: value, offset: '0, count: '0,
          partial: 1'b0, typed: 1'b0, span: SPAN_ERR};
    return r;
  endfunction

  initial begin
    logic [31:0] first, size_r;
    logic [15:0] size;
    // reset geometry: one block of 512 bytes at block 0
    directed_rows = '{
      item_row(48'd0, 32'd1, 1'b0, 1, '{1'b0, 32'd0, 16'd0, 32'd0, 16'd0, 32'd0}),
      item_row(48'd0, 32'd512, 1'b0, 1, '{1'b0, 32'd0, 16'd0, 32'd0, 16'd511, 32'd1}),
      item_row(-48'sd1, 32'd1, 1'b0, 1, '{1'b0, 32'd0, 16'd511, 32'd0, 16'd511, 32'd0}),
      item_row(-48'sd512, 32'd512, 1'b0, 1, '{1'b0, 32'd0, 16'd0, 32'd0, 16'd511, 32'd1}),
      item_row(48'd512, 32'd1, 1'b0, 1, SPAN_ERR),
      item_row(48'd0, 32'd0, 1'b1, 1, SPAN_ERR),
      item_row(48'd0, 32'd513, 1'b0, 1, SPAN_ERR),
      item_row(48'd0, 32'd513, 1'b1, 1, '{1'b0, 32'd0, 16'd0, 32'd0, 16'd511, 32'd1}),
      item_row(48'h7FFF_FFFF_FFFF, 32'd1, 1'b1, 1, SPAN_ERR),
      item_row(48'h8000_0000_0000, 32'd1, 1'b1, 1, SPAN_ERR),
      item_row(-48'sd2, 32'hFFFF_FFFF, 1'b1, 0, SPAN_ERR),
      cfg_row(REG_BLOCK_SIZE, 32'd0),
      item_row(48'd0, 32'd1, 1'b1, 1, SPAN_ERR),
      cfg_row(REG_BLOCK_SIZE, 32'd1),
      cfg_row(REG_PART_LAST, 32'hFFFF_FFFF),
      item_row(48'd0, 32'hFFFF_FFFF, 1'b1, 0, SPAN_ERR),
      item_row(-48'sd1, 32'hFFFF_FFFF, 1'b1, 0, SPAN_ERR),
      item_row(-48'sh1_0000_0000, 32'hFFFF_FFFF, 1'b0, 0, SPAN_ERR),
      cfg_row(REG_PART_FIRST, 32'd5),
      cfg_row(REG_PART_LAST, 32'd4),
      item_row(48'd0, 32'd1, 1'b1, 1, SPAN_ERR),
      cfg_row(REG_PART_LAST, 32'hFFFF_FFFF),
      cfg_row(REG_PART_FIRST, 32'hFFFF_FFFF),
      cfg_row(REG_BLOCK_SIZE, 32'hFFFF),
      item_row(48'd65534, 32'd2, 1'b1, 0, SPAN_ERR),
      item_row(-48'sd65536, 32'd1, 1'b0, 0, SPAN_ERR)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        idle_request();
        drain_and_settle();
        write_reg(directed_rows[i].index, directed_rows[i].data);
      end else begin
        send_request(directed_rows[i].offset, directed_rows[i].count,
                     directed_rows[i].partial, directed_rows[i].typed,
                     directed_rows[i].span);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_request();
      first = $urandom;
      case ($urandom_range(0, 4))
        0:       size = 16'd1;
        1:       size = 16'hFFFF;
        2:       size = 16'd512;
        default: size = $urandom_range(1, 4096);
      endcase
      if (ph == 1) size = 16'd0;
      case (ph)
        2:       set_partition(32'd0, 32'hFFFF_FFFF, 16'd1);
        4:       set_partition(first, first - 32'd1 - $urandom_range(0, 3), size);
        6:       set_partition(32'hFFFF_FFFF, 32'hFFFF_FFFF, size);
        default: begin
          size_r = $urandom_range(0, 40);
          if (first > 32'hFFFF_FFFF - size_r) first = 32'hFFFF_FFFF - size_r;
          set_partition(first, first + size_r, size);
        end
      endcase
      if (ph == 3) long_hold = 1;
      repeat (ITEMS_PER_PHASE) send_random();
    end

    idle_request();
    drain_and_settle();
    if (fails == 0 && pending_spans.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
